// ===== src/vpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and codes of the variable-partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

	localparam int ADDR_W = 20;
	localparam int LEN_W = 21;
	localparam int PID_W = 16;
	localparam logic [LEN_W-1:0] MEM_LIMIT = 21'd1048576;
	localparam logic [LEN_W-1:0] MEM_RESET = 21'd4096;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOFIT = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST = 2'd1,
		FIT_WORST = 2'd2,
		FIT_SPARE = 2'd3
	} fit_t;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic CFG_FIT = 1'b0;
	localparam logic CFG_SIZE = 1'b1;

endpackage

// ===== src/variable_partition_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_partition_allocator
// First, best or worst fit allocator over a base-ordered hole list and an
// allocation table, both kept in synchronous memories with a registered read.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. After reset the block
// loads the initial hole in its init state before busy drops. One sequencer
// walks the hole memory and the table memory one entry per cycle, since each
// memory has a single read port. An allocate holds busy through a check
// state, a scan of the holes, a carve state and, when the hole is emptied, a
// pass that moves the later holes down. A release holds busy while it looks
// at table entries and moves later ones up, through a start state, and while
// it passes, moves or merges holes. The result appears for one cycle with
// done high, possibly while busy is still high, and must be taken then: the
// receiver cannot stall. A memory_size write rebuilds the lists through the
// fill counts in a single write; no clearing pass is needed.
// ----------------------------------------------------------------------------
module variable_partition_allocator import vpa_pkg::*; #(
	parameter int MAX_ALLOCATIONS = 16,
	parameter int MAX_FREE_BLOCKS = 17
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              operation,
	input  logic [PID_W-1:0]  process_id,
	input  logic [LEN_W-1:0]  request_size,
	output logic              done,
	output logic [ADDR_W-1:0] block_base,
	output logic [LEN_W-1:0]  block_size,
	output logic [1:0]        status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [LEN_W-1:0]  cfg_data
);

	localparam int FW = $clog2(MAX_FREE_BLOCKS);
	localparam int AW = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;
	localparam int FCW = $clog2(MAX_FREE_BLOCKS + 1);
	localparam int ACW = $clog2(MAX_ALLOCATIONS + 1);
	localparam logic [FCW-1:0] FMAX = FCW'(MAX_FREE_BLOCKS);
	localparam logic [ACW-1:0] AMAX = ACW'(MAX_ALLOCATIONS);

	typedef enum logic [10:0] {
		S_INIT   = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_ACHK   = 11'b00000000100,
		S_SCAN   = 11'b00000001000,
		S_CARVE  = 11'b00000010000,
		S_DROP   = 11'b00000100000,
		S_LOOK   = 11'b00001000000,
		S_RM     = 11'b00010000000,
		S_HSTART = 11'b00100000000,
		S_HFIND  = 11'b01000000000,
		S_INS    = 11'b10000000000
	} state_t;

	state_t state_q;

	// Hole memory and allocation table memory.
	logic [ADDR_W+LEN_W-1:0] hole_mem [MAX_FREE_BLOCKS];
	logic [PID_W+ADDR_W+LEN_W-1:0] tab_mem [MAX_ALLOCATIONS];
	logic [ADDR_W+LEN_W-1:0] hole_rd;
	logic [PID_W+ADDR_W+LEN_W-1:0] tab_rd;
	logic [FW-1:0] h_ra, h_wa;
	logic h_we;
	logic [ADDR_W+LEN_W-1:0] h_wd;
	logic [AW-1:0] t_ra, t_wa;
	logic t_we;
	logic [PID_W+ADDR_W+LEN_W-1:0] t_wd;

	always_ff @(posedge clk) begin
		if (h_we) hole_mem[h_wa] <= h_wd;
		hole_rd <= hole_mem[h_ra];
		if (t_we) tab_mem[t_wa] <= t_wd;
		tab_rd <= tab_mem[t_ra];
	end

	logic [1:0] fit_q;
	logic [FCW-1:0] fcnt_q;
	logic [ACW-1:0] acnt_q;
	logic [FCW-1:0] fi_q;
	logic [ACW-1:0] ai_q;
	logic [PID_W-1:0] pid_q;
	logic [LEN_W-1:0] size_q;
	logic found_q;
	logic [FW-1:0] pick_q;
	logic [ADDR_W-1:0] pbase_q;
	logic [LEN_W-1:0] plen_q;
	logic [ADDR_W-1:0] rbase_q;
	logic [LEN_W-1:0] rlen_q;
	logic [ADDR_W-1:0] lbase_q;
	logic [LEN_W-1:0] llen_q;
	logic lvalid_q;
	logic [ADDR_W+LEN_W-1:0] carry_q;

	logic [ADDR_W-1:0] rd_b;
	logic [LEN_W-1:0] rd_l;
	logic [PID_W-1:0] tab_pid;
	logic [LEN_W:0] lend;
	logic [LEN_W:0] rend;
	logic [LEN_W:0] rbase_w;
	logic [LEN_W:0] rdb_w;
	logic better;
	logic scan_last;
	logic h_in;
	logic h_left;
	logic ltouch;
	logic rtouch;
	logic [FCW-1:0] fi_n1;
	logic [FCW-1:0] fi_n2;
	logic [FCW-1:0] fi_m1;
	logic [ACW-1:0] ai_n1;
	logic [ACW-1:0] ai_n2;
	logic [FW-1:0] pick_n1;
	logic [LEN_W-1:0] cfg_sat;

	assign rd_b = hole_rd[ADDR_W+LEN_W-1:LEN_W];
	assign rd_l = hole_rd[LEN_W-1:0];
	assign tab_pid = tab_rd[PID_W+ADDR_W+LEN_W-1:ADDR_W+LEN_W];
	assign rbase_w = {{(LEN_W+1-ADDR_W){1'b0}}, rbase_q};
	assign rdb_w = {{(LEN_W+1-ADDR_W){1'b0}}, rd_b};
	assign lend = {{(LEN_W+1-ADDR_W){1'b0}}, lbase_q} + {1'b0, llen_q};
	assign rend = rbase_w + {1'b0, rlen_q};
	assign fi_n1 = fi_q + FCW'(1);
	assign fi_n2 = fi_q + FCW'(2);
	assign fi_m1 = fi_q - FCW'(1);
	assign ai_n1 = ai_q + ACW'(1);
	assign ai_n2 = ai_q + ACW'(2);
	assign pick_n1 = pick_q + FW'(1);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !start;
	assign cfg_sat = (cfg_data > MEM_LIMIT) ? MEM_LIMIT : cfg_data;

	// Hole choice for the entry under scan.
	always_comb begin
		better = 1'b0;
		if (rd_l >= size_q) begin
			if (!found_q) better = 1'b1;
			else if (fit_q == FIT_BEST) better = rd_l < plen_q;
			else if (fit_q == FIT_WORST) better = rd_l > plen_q;
		end
	end

	assign scan_last = (better && fit_q != FIT_BEST && fit_q != FIT_WORST)
		|| (fi_n1 >= fcnt_q);

	// Neighbors of a released block in the hole list.
	assign h_in = fi_q < fcnt_q;
	assign h_left = h_in && (rd_b < rbase_q);
	assign ltouch = lvalid_q && (lend == rbase_w);
	assign rtouch = h_in && (rend == rdb_w);

	// Memory port control, driven from the sequencer state.
	always_comb begin
		h_ra = fi_q[FW-1:0];
		h_we = 1'b0;
		h_wa = fi_q[FW-1:0];
		h_wd = '0;
		t_ra = ai_q[AW-1:0];
		t_we = 1'b0;
		t_wa = ai_q[AW-1:0];
		t_wd = '0;
		case (state_q)
			S_INIT: begin
				h_we = 1'b1;
				h_wa = '0;
				h_wd = {{ADDR_W{1'b0}}, MEM_RESET};
			end
			S_IDLE: begin
				h_ra = '0;
				t_ra = '0;
				if (cfg_valid && cfg_ready && cfg_index == CFG_SIZE) begin
					h_we = 1'b1;
					h_wa = '0;
					h_wd = {{ADDR_W{1'b0}}, cfg_sat};
				end
			end
			S_SCAN: h_ra = fi_n1[FW-1:0];
			S_CARVE: begin
				h_we = 1'b1;
				h_wa = pick_q;
				h_wd = {pbase_q + size_q[ADDR_W-1:0], plen_q - size_q};
				t_we = 1'b1;
				t_wa = acnt_q[AW-1:0];
				t_wd = {pid_q, pbase_q, size_q};
				h_ra = pick_n1;
			end
			// Move the next hole down over the current slot.
			S_DROP: begin
				h_we = 1'b1;
				h_wd = hole_rd;
				h_ra = fi_n2[FW-1:0];
			end
			S_LOOK: t_ra = ai_n1[AW-1:0];
			// Move the next table entry up over the current slot.
			S_RM: begin
				t_we = 1'b1;
				t_wd = tab_rd;
				t_ra = ai_n2[AW-1:0];
			end
			S_HFIND: begin
				h_ra = fi_n1[FW-1:0];
				if (!h_left) begin
					if (ltouch && rtouch) begin
						h_we = 1'b1;
						h_wa = fi_m1[FW-1:0];
						h_wd = {lbase_q, llen_q + rlen_q + rd_l};
					end else if (ltouch) begin
						h_we = 1'b1;
						h_wa = fi_m1[FW-1:0];
						h_wd = {lbase_q, llen_q + rlen_q};
					end else if (rtouch) begin
						h_we = 1'b1;
						h_wd = {rbase_q, rlen_q + rd_l};
					end else if (fcnt_q < FMAX) begin
						h_we = 1'b1;
						h_wd = {rbase_q, rlen_q};
					end
				end
			end
			// Insert: write the carried hole, the displaced one is read.
			S_INS: begin
				h_we = 1'b1;
				h_wd = carry_q;
				h_ra = fi_n1[FW-1:0];
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			fit_q <= FIT_FIRST;
			fcnt_q <= FCW'(1);
			acnt_q <= '0;
			done <= 1'b0;
			status <= ST_OK;
			block_base <= '0;
			block_size <= '0;
			fi_q <= '0;
			ai_q <= '0;
			pid_q <= '0;
			size_q <= '0;
			found_q <= 1'b0;
			pick_q <= '0;
			pbase_q <= '0;
			plen_q <= '0;
			rbase_q <= '0;
			rlen_q <= '0;
			lbase_q <= '0;
			llen_q <= '0;
			lvalid_q <= 1'b0;
			carry_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						if (cfg_index == CFG_FIT) fit_q <= cfg_data[1:0];
						else begin
							acnt_q <= '0;
							fcnt_q <= (cfg_data == '0) ? '0 : FCW'(1);
						end
					end
					if (start) begin
						pid_q <= process_id;
						size_q <= request_size;
						fi_q <= '0;
						ai_q <= '0;
						found_q <= 1'b0;
						lvalid_q <= 1'b0;
						if (operation == OP_ALLOC) state_q <= S_ACHK;
						else state_q <= S_LOOK;
					end
				end
				// Table full, empty request and empty hole list checks before the scan.
				S_ACHK: begin
					if (acnt_q >= AMAX || size_q == '0 || fcnt_q == '0) begin
						status <= (acnt_q >= AMAX) ? ST_FULL : ST_NOFIT;
						block_base <= '0;
						block_size <= '0;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else state_q <= S_SCAN;
				end
				// Hole fi_q is in the read register; the next one is being read.
				S_SCAN: begin
					if (better) begin
						found_q <= 1'b1;
						pick_q <= fi_q[FW-1:0];
						pbase_q <= rd_b;
						plen_q <= rd_l;
					end
					if (!scan_last) fi_q <= fi_n1;
					else if (found_q || better) state_q <= S_CARVE;
					else begin
						status <= ST_NOFIT;
						block_base <= '0;
						block_size <= '0;
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_CARVE: begin
					acnt_q <= acnt_q + ACW'(1);
					status <= ST_OK;
					block_base <= pbase_q;
					block_size <= size_q;
					done <= 1'b1;
					if (plen_q == size_q) begin
						if (FCW'(pick_q) + FCW'(1) < fcnt_q) begin
							fi_q <= FCW'(pick_q);
							state_q <= S_DROP;
						end else begin
							fcnt_q <= fcnt_q - FCW'(1);
							state_q <= S_IDLE;
						end
					end else state_q <= S_IDLE;
				end
				S_DROP: begin
					if (fi_n2 >= fcnt_q) begin
						fcnt_q <= fcnt_q - FCW'(1);
						state_q <= S_IDLE;
					end else fi_q <= fi_n1;
				end
				// Table entry ai_q is in the read register.
				S_LOOK: begin
					if (ai_q >= acnt_q) begin
						status <= ST_NOTFOUND;
						block_base <= '0;
						block_size <= '0;
						done <= 1'b1;
						state_q <= S_IDLE;
					end else if (tab_pid == pid_q) begin
						rbase_q <= tab_rd[ADDR_W+LEN_W-1:LEN_W];
						rlen_q <= tab_rd[LEN_W-1:0];
						status <= ST_OK;
						block_base <= tab_rd[ADDR_W+LEN_W-1:LEN_W];
						block_size <= tab_rd[LEN_W-1:0];
						done <= 1'b1;
						fi_q <= '0;
						if (ai_n1 < acnt_q) state_q <= S_RM;
						else begin
							acnt_q <= acnt_q - ACW'(1);
							state_q <= S_HSTART;
						end
					end else ai_q <= ai_n1;
				end
				S_RM: begin
					if (ai_n2 >= acnt_q) begin
						acnt_q <= acnt_q - ACW'(1);
						state_q <= S_HSTART;
					end else ai_q <= ai_n1;
				end
				// First hole is read here for the position search.
				S_HSTART: state_q <= S_HFIND;
				// Find the first hole at or above the released base, then merge or insert.
				S_HFIND: begin
					if (h_left) begin
						lvalid_q <= 1'b1;
						lbase_q <= rd_b;
						llen_q <= rd_l;
						fi_q <= fi_n1;
					end else if (ltouch && rtouch) begin
						if (fi_n1 < fcnt_q) state_q <= S_DROP;
						else begin
							fcnt_q <= fcnt_q - FCW'(1);
							state_q <= S_IDLE;
						end
					end else if (!ltouch && !rtouch && fcnt_q < FMAX) begin
						carry_q <= hole_rd;
						if (fi_q >= fcnt_q) begin
							fcnt_q <= fcnt_q + FCW'(1);
							state_q <= S_IDLE;
						end else begin
							fi_q <= fi_n1;
							state_q <= S_INS;
						end
					end else state_q <= S_IDLE;
				end
				S_INS: begin
					if (fi_q >= fcnt_q) begin
						fcnt_q <= fcnt_q + FCW'(1);
						state_q <= S_IDLE;
					end else begin
						carry_q <= hole_rd;
						fi_q <= fi_n1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
